// ===== hdl/wssr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wssr_pkg
// Shared widths, limits and register indexes of the windowed slot
// reservation controller.
// ============================================================================
package wssr_pkg;

    localparam int MAX_WINDOW    = 1024;
    localparam int INITIAL_SLOTS = 0;

    localparam int WAIT_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int WIN_W    = 11;
    localparam int PCT_W    = 7;
    localparam int SLOT_W   = 16;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    // 100 * violations and window * percent both fit here
    localparam int CMP_W    = WIN_W + PCT_W;

    localparam int PCT_MAX  = 100;

    // reset values of the registers
    localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(1);
    localparam logic [PCT_W-1:0]  PCT_RST  = PCT_W'(100);
    localparam logic [SLOT_W-1:0] STEP_RST = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] MIN_RST  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] MAX_RST  = SLOT_W'(0);

    // initial slot count clamped into min..max(min, max) at reset values
    localparam int EFF_MAX_RST = (MAX_RST > MIN_RST) ? int'(MAX_RST) : int'(MIN_RST);
    localparam int INIT_LO     = (INITIAL_SLOTS < int'(MIN_RST)) ? int'(MIN_RST)
                                                                 : INITIAL_SLOTS;
    localparam int INIT_CLAMP  = (INIT_LO > EFF_MAX_RST) ? EFF_MAX_RST : INIT_LO;
    localparam logic [SLOT_W-1:0] SLOTS_RST = SLOT_W'(INIT_CLAMP);

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_WAIT    = 3'd0,
        REG_PRIORITY_FLOOR = 3'd1,
        REG_WINDOW_LENGTH  = 3'd2,
        REG_VIOL_PERCENT   = 3'd3,
        REG_INCREASE_STEP  = 3'd4,
        REG_DECREASE_STEP  = 3'd5,
        REG_MIN_SLOTS      = 3'd6,
        REG_MAX_SLOTS      = 3'd7
    } t_reg_idx;

endpackage

// ===== hdl/windowed_slo_slot_reservation.sv =====
`timescale 1ns / 1ps
// ============================================================================
// windowed_slo_slot_reservation
// Windowed wait-target controller that adjusts a reserved slot count.
// ============================================================================
// Each accepted request observation is handled in the cycle it is accepted:
// the window counters and the slot count are updated at once and the result
// lands in a single output register, so one request is taken every cycle
// unless the output stalls, and its result is valid in the next cycle. The
// input stays ready while a result waits, as long as it is being taken in the
// same cycle. The window threshold test is done as 100 * violations >=
// window * percent, which needs no divider. Configuration writes take effect
// on the next cycle and must be made while no request is in flight.
module windowed_slo_slot_reservation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_cfg_wr_en,
    input  logic [wssr_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [wssr_pkg::CFG_W-1:0]         i_cfg_wdata,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [wssr_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic [wssr_pkg::WAIT_W-1:0]        i_queue_wait,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_changed,
    output logic [wssr_pkg::SLOT_W-1:0]        o_slot_count,
    output logic [wssr_pkg::WIN_W-1:0]         o_samples_in_window
);

    // configuration
    logic [wssr_pkg::WAIT_W-1:0] r_target_wait;
    logic [wssr_pkg::PRIO_W-1:0] r_prio_floor;
    logic [wssr_pkg::WIN_W-1:0]  r_win_len;
    logic [wssr_pkg::PCT_W-1:0]  r_pct;
    logic [wssr_pkg::SLOT_W-1:0] r_inc_step;
    logic [wssr_pkg::SLOT_W-1:0] r_dec_step;
    logic [wssr_pkg::SLOT_W-1:0] r_min_slots;
    logic [wssr_pkg::SLOT_W-1:0] r_max_slots;

    // state
    logic [wssr_pkg::WIN_W-1:0]  r_samples, n_samples;
    logic [wssr_pkg::WIN_W-1:0]  r_viols, n_viols;
    logic [wssr_pkg::SLOT_W-1:0] r_slots, n_slots;

    // result register
    logic                        r_out_valid;
    logic                        r_changed, n_changed;
    logic [wssr_pkg::SLOT_W-1:0] r_out_slots;
    logic [wssr_pkg::WIN_W-1:0]  r_out_samples;

    logic                        accept;
    logic                        active;
    logic                        close;
    logic                        violated;
    logic [wssr_pkg::WIN_W-1:0]  eff_win;
    logic [wssr_pkg::PCT_W-1:0]  eff_pct;
    logic [wssr_pkg::SLOT_W-1:0] eff_max;
    logic [wssr_pkg::SLOT_W-1:0] eff_inc;
    logic [wssr_pkg::SLOT_W-1:0] eff_dec;
    logic [wssr_pkg::SLOT_W-1:0] room_up;
    logic [wssr_pkg::SLOT_W-1:0] room_dn;
    logic [wssr_pkg::SLOT_W-1:0] slots_adj;
    logic [wssr_pkg::WIN_W-1:0]  samples_inc;
    logic [wssr_pkg::WIN_W-1:0]  viols_inc;
    logic [wssr_pkg::CMP_W-1:0]  viol_scaled;
    logic [wssr_pkg::CMP_W-1:0]  need_scaled;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign o_out_valid         = r_out_valid;
    assign o_changed           = r_changed;
    assign o_slot_count        = r_out_slots;
    assign o_samples_in_window = r_out_samples;

    // clamp registers at use
    always_comb begin
        if (r_win_len == '0) begin
            eff_win = wssr_pkg::WIN_W'(1);
        end else if (r_win_len > wssr_pkg::WIN_W'(wssr_pkg::MAX_WINDOW)) begin
            eff_win = wssr_pkg::WIN_W'(wssr_pkg::MAX_WINDOW);
        end else begin
            eff_win = r_win_len;
        end

        if (r_pct == '0) begin
            eff_pct = wssr_pkg::PCT_W'(1);
        end else if (r_pct > wssr_pkg::PCT_W'(wssr_pkg::PCT_MAX)) begin
            eff_pct = wssr_pkg::PCT_W'(wssr_pkg::PCT_MAX);
        end else begin
            eff_pct = r_pct;
        end

        eff_max = (r_max_slots > r_min_slots) ? r_max_slots : r_min_slots;
        eff_inc = (r_inc_step == '0) ? wssr_pkg::SLOT_W'(1) : r_inc_step;
        eff_dec = (r_dec_step == '0) ? wssr_pkg::SLOT_W'(1) : r_dec_step;
    end

    // window update and slot adjustment
    always_comb begin
        active      = (r_target_wait != '0) && (i_priority_req >= r_prio_floor);
        samples_inc = r_samples + wssr_pkg::WIN_W'(1);
        viols_inc   = (i_queue_wait > r_target_wait) ? (r_viols + wssr_pkg::WIN_W'(1))
                                                     : r_viols;
        close       = samples_inc >= eff_win;

        // violations >= ceil(win * pct / 100)  <=>  100 * violations >= win * pct
        viol_scaled = wssr_pkg::CMP_W'(viols_inc) * wssr_pkg::CMP_W'(wssr_pkg::PCT_MAX);
        need_scaled = wssr_pkg::CMP_W'(eff_win) * wssr_pkg::CMP_W'(eff_pct);
        violated    = viol_scaled >= need_scaled;

        room_up = eff_max - r_slots;
        room_dn = r_slots - r_min_slots;

        if (violated) begin
            if (r_slots < eff_max) begin
                slots_adj = r_slots + ((eff_inc < room_up) ? eff_inc : room_up);
            end else begin
                slots_adj = r_slots;
            end
        end else if (r_slots > r_min_slots) begin
            slots_adj = r_slots - ((eff_dec < room_dn) ? eff_dec : room_dn);
        end else begin
            slots_adj = r_slots;
        end

        n_samples = r_samples;
        n_viols   = r_viols;
        n_slots   = r_slots;
        n_changed = 1'b0;
        if (active) begin
            if (close) begin
                n_samples = '0;
                n_viols   = '0;
                n_slots   = slots_adj;
                n_changed = slots_adj != r_slots;
            end else begin
                n_samples = samples_inc;
                n_viols   = viols_inc;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_wait <= '0;
            r_prio_floor  <= '0;
            r_win_len     <= wssr_pkg::WIN_RST;
            r_pct         <= wssr_pkg::PCT_RST;
            r_inc_step    <= wssr_pkg::STEP_RST;
            r_dec_step    <= wssr_pkg::STEP_RST;
            r_min_slots   <= wssr_pkg::MIN_RST;
            r_max_slots   <= wssr_pkg::MAX_RST;
        end else if (i_cfg_wr_en) begin
            case (wssr_pkg::t_reg_idx'(i_cfg_index))
                wssr_pkg::REG_TARGET_WAIT: begin
                    r_target_wait <= i_cfg_wdata[wssr_pkg::WAIT_W-1:0];
                end
                wssr_pkg::REG_PRIORITY_FLOOR: begin
                    r_prio_floor <= i_cfg_wdata[wssr_pkg::PRIO_W-1:0];
                end
                wssr_pkg::REG_WINDOW_LENGTH: begin
                    r_win_len <= i_cfg_wdata[wssr_pkg::WIN_W-1:0];
                end
                wssr_pkg::REG_VIOL_PERCENT: begin
                    r_pct <= i_cfg_wdata[wssr_pkg::PCT_W-1:0];
                end
                wssr_pkg::REG_INCREASE_STEP: begin
                    r_inc_step <= i_cfg_wdata[wssr_pkg::SLOT_W-1:0];
                end
                wssr_pkg::REG_DECREASE_STEP: begin
                    r_dec_step <= i_cfg_wdata[wssr_pkg::SLOT_W-1:0];
                end
                wssr_pkg::REG_MIN_SLOTS: begin
                    r_min_slots <= i_cfg_wdata[wssr_pkg::SLOT_W-1:0];
                end
                wssr_pkg::REG_MAX_SLOTS: begin
                    r_max_slots <= i_cfg_wdata[wssr_pkg::SLOT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // window state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples   <= '0;
            r_viols     <= '0;
            r_slots     <= wssr_pkg::SLOTS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_samples   <= n_samples;
                r_viols     <= n_viols;
                r_slots     <= n_slots;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_changed     <= n_changed;
            r_out_slots   <= n_slots;
            r_out_samples <= n_samples;
        end
    end

endmodule
